>>> design/hafcr_pkg.sv
// shared types, constants and a helper function for the hex ascii frame receiver
// no dependencies
package hafcr_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int HDR_DEPTH   = 3;
  localparam int CNT_BITS    = $clog2(FRAME_BYTES + 1);
  localparam int CNT_W       = (CNT_BITS > 6) ? CNT_BITS : 6;

  localparam logic [7:0] CH_OPEN  = 8'h40;
  localparam logic [7:0] CH_CLOSE = 8'h21;

  localparam logic [7:0] HDR_CMD_DIR    = 8'h01;
  localparam logic [7:0] HDR_CMD_LED    = 8'h02;
  localparam logic [7:0] HDR_CMD_SENSOR = 8'h04;

  localparam logic [CNT_W-1:0] FRAME_FULL = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_SAT    = CNT_W'(63);

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_DIR    = 2'd1,
    CMD_LED    = 2'd2,
    CMD_SENSOR = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [HDR_DEPTH-1:0][7:0] hdr;
    logic [CNT_W-1:0]          count;
    logic                      ovf;
  } hdr_snap_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] line_follow_mode;
    logic [7:0] direction_code;
    logic       direction_valid;
    logic       recompute_direction;
    logic [7:0] led_pattern;
    logic [5:0] payload_bytes;
    logic       overflow;
  } result_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = 4'(c[3:0] + 4'h9);
    end
    return n;
  endfunction

endpackage

>>> design/hafcr_framer.sv
// frame state: open/close tracking, nibble packing and header byte store
// depends on hafcr_pkg
module hafcr_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_word,
  output hafcr_pkg::hdr_snap_t snap
);

  logic                                  in_frame, in_frame_next;
  logic [hafcr_pkg::CNT_W-1:0]           byte_count, byte_count_next;
  logic                                  low_nibble_next, low_nibble_next_next;
  logic                                  overflow_seen, overflow_seen_next;
  logic [hafcr_pkg::HDR_DEPTH-1:0][7:0]  header_store, header_store_next;
  logic [3:0]                            nib;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_count      <= '0;
      low_nibble_next <= 1'b0;
      overflow_seen   <= 1'b0;
      header_store    <= '0;
    end else if (step) begin
      in_frame        <= in_frame_next;
      byte_count      <= byte_count_next;
      low_nibble_next <= low_nibble_next_next;
      overflow_seen   <= overflow_seen_next;
      header_store    <= header_store_next;
    end
  end

  always_comb begin
    nib                  = hafcr_pkg::hex_nibble(rx_word);
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    low_nibble_next_next = low_nibble_next;
    overflow_seen_next   = overflow_seen;
    header_store_next    = header_store;
    priority if (rx_word == hafcr_pkg::CH_OPEN) begin
      in_frame_next        = 1'b1;
      byte_count_next      = '0;
      low_nibble_next_next = 1'b0;
      overflow_seen_next   = 1'b0;
      header_store_next    = '0;
    end else if (rx_word == hafcr_pkg::CH_CLOSE) begin
      in_frame_next = 1'b0;
    end else if (in_frame) begin
      low_nibble_next_next = !low_nibble_next;
      if (byte_count >= hafcr_pkg::FRAME_FULL) begin
        overflow_seen_next = 1'b1;
      end else begin
        for (int i = 0; i < hafcr_pkg::HDR_DEPTH; i++) begin
          if (byte_count == hafcr_pkg::CNT_W'(i)) begin
            header_store_next[i] = low_nibble_next ? (header_store[i] | {4'h0, nib})
                                                   : (header_store[i] | {nib, 4'h0});
          end
        end
        if (low_nibble_next) begin
          byte_count_next = byte_count + hafcr_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign snap.hdr   = header_store;
  assign snap.count = byte_count;
  assign snap.ovf   = overflow_seen;

endmodule

>>> design/hafcr_decoder.sv
// command decode of the stored header bytes into result fields
// depends on hafcr_pkg
module hafcr_decoder (
  input  hafcr_pkg::hdr_snap_t snap,
  output hafcr_pkg::result_t   res
);

  always_comb begin
    res = '0;
    unique case (snap.hdr[0])
      hafcr_pkg::HDR_CMD_DIR: begin
        res.kind             = hafcr_pkg::CMD_DIR;
        res.line_follow_mode = snap.hdr[1];
        if (snap.hdr[1] == 8'h00) begin
          res.direction_code  = snap.hdr[2];
          res.direction_valid = 1'b1;
        end else begin
          res.recompute_direction = 1'b1;
        end
      end
      hafcr_pkg::HDR_CMD_LED: begin
        res.kind        = hafcr_pkg::CMD_LED;
        res.led_pattern = snap.hdr[1];
      end
      hafcr_pkg::HDR_CMD_SENSOR: begin
        res.kind = hafcr_pkg::CMD_SENSOR;
      end
      default: begin
        res.kind = hafcr_pkg::CMD_NONE;
      end
    endcase
    res.payload_bytes = (snap.count > hafcr_pkg::CNT_SAT) ? 6'd63 : snap.count[5:0];
    res.overflow      = snap.ovf;
  end

endmodule

>>> design/hex_ascii_frame_command_receiver_core.sv
// hex ascii frame command receiver, top level
// an accepted '!' word is registered in s1_byte, then its decoded result is registered in res_q for the outputs
// throughput: one word per cycle; only '!' words wait on the result register
// reset: synchronous, clears frame state, header store and both valid flags
// depends on hafcr_pkg, hafcr_framer, hafcr_decoder
module hex_ascii_frame_command_receiver_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] command_kind,
  output logic [7:0] line_follow_mode,
  output logic [7:0] direction_code,
  output logic       direction_valid,
  output logic       recompute_direction,
  output logic [7:0] led_pattern,
  output logic [5:0] payload_bytes,
  output logic       overflow
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_close, s1_go, slot_free;
  hafcr_pkg::hdr_snap_t snap;
  hafcr_pkg::result_t   res, res_q;

  assign s1_close  = (s1_byte == hafcr_pkg::CH_CLOSE);
  assign slot_free = !out_valid || out_ready;
  assign s1_go     = s1_valid && (!s1_close || slot_free);
  assign in_ready  = !rst && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  hafcr_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .rx_word (s1_byte),
    .snap    (snap)
  );

  hafcr_decoder u_decoder (
    .snap (snap),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_close) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_close) begin
      res_q <= res;
    end
  end

  assign command_kind        = res_q.kind;
  assign line_follow_mode    = res_q.line_follow_mode;
  assign direction_code      = res_q.direction_code;
  assign direction_valid     = res_q.direction_valid;
  assign recompute_direction = res_q.recompute_direction;
  assign led_pattern         = res_q.led_pattern;
  assign payload_bytes       = res_q.payload_bytes;
  assign overflow            = res_q.overflow;

endmodule

>>> design/hafcr_checker.sv
// port-level checks for the hex ascii frame receiver, with bind to the top level
// depends on hafcr_pkg and hex_ascii_frame_command_receiver_core
module hafcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] command_kind,
  input logic [7:0] line_follow_mode,
  input logic [7:0] direction_code,
  input logic       direction_valid,
  input logic       recompute_direction,
  input logic [7:0] led_pattern,
  input logic [5:0] payload_bytes
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command_kind)
      && $stable(payload_bytes) && $stable(direction_code))
    else $error("result changed while stalled");

  a_dir_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (direction_valid || recompute_direction) |->
      command_kind == hafcr_pkg::CMD_DIR && (direction_valid != recompute_direction)
      && (recompute_direction == (line_follow_mode != 8'h00)))
    else $error("direction flags inconsistent");

  a_dir_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind != hafcr_pkg::CMD_DIR |->
      line_follow_mode == 8'h00 && direction_code == 8'h00 && !direction_valid
      && !recompute_direction)
    else $error("direction fields set for another command");

  a_led_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind != hafcr_pkg::CMD_LED |-> led_pattern == 8'h00)
    else $error("led field set for another command");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (payload_bytes <= 6'(hafcr_pkg::FRAME_BYTES)) || (payload_bytes == 6'd63))
    else $error("payload count above frame size");

endmodule

bind hex_ascii_frame_command_receiver_core hafcr_checker u_hafcr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .command_kind        (command_kind),
  .line_follow_mode    (line_follow_mode),
  .direction_code      (direction_code),
  .direction_valid     (direction_valid),
  .recompute_direction (recompute_direction),
  .led_pattern         (led_pattern),
  .payload_bytes       (payload_bytes)
);

>>> tb/hex_ascii_frame_command_receiver_core_tb.sv
// self-checking testbench for hex_ascii_frame_command_receiver_core: directed table, then
// random frames under several idle/stall mixes, checked against an in-bench frame decoder
// depends on hafcr_pkg and the design under test
module hex_ascii_frame_command_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    logic [7:0]         ch;
    bit                 fixed;
    hafcr_pkg::result_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] command_kind;
  logic [7:0] line_follow_mode;
  logic [7:0] direction_code;
  logic       direction_valid;
  logic       recompute_direction;
  logic [7:0] led_pattern;
  logic [5:0] payload_bytes;
  logic       overflow;

  // decoder state kept by the bench
  bit          frame_open;
  int unsigned bytes_done;
  bit          low_half;
  bit          ovf_flag;
  logic [7:0]  hdr_bytes [hafcr_pkg::HDR_DEPTH];

  hafcr_pkg::result_t pending_results [$];
  int          mismatches = 0;
  int          items_done = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  stim_row_t   dir_tab [26];

  hex_ascii_frame_command_receiver_core DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .rx_byte             (rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .command_kind        (command_kind),
    .line_follow_mode    (line_follow_mode),
    .direction_code      (direction_code),
    .direction_valid     (direction_valid),
    .recompute_direction (recompute_direction),
    .led_pattern         (led_pattern),
    .payload_bytes       (payload_bytes),
    .overflow            (overflow)
  );

  always #5 clk = ~clk;

  function automatic hafcr_pkg::result_t frame_result(input hafcr_pkg::cmd_kind_t k,
                                                      input logic [7:0] lf,
                                                      input logic [7:0] dc, input logic dv,
                                                      input logic rc, input logic [7:0] led,
                                                      input logic [5:0] cnt, input logic ovf);
    hafcr_pkg::result_t r;
    r.kind = k;
    r.line_follow_mode = lf;
    r.direction_code = dc;
    r.direction_valid = dv;
    r.recompute_direction = rc;
    r.led_pattern = led;
    r.payload_bytes = cnt;
    r.overflow = ovf;
    return r;
  endfunction

  // advances the decoder by one character, returns 1 on every '!', which yields a result word
  function automatic bit decode_char(input logic [7:0] c, output hafcr_pkg::result_t r);
    logic [3:0] nib;
    r = '0;
    nib = 4'h0;
    if (c == hafcr_pkg::CH_OPEN) begin
      frame_open = 1'b1;
      bytes_done = 0;
      low_half = 1'b0;
      ovf_flag = 1'b0;
      foreach (hdr_bytes[j]) hdr_bytes[j] = 8'h00;
      return 1'b0;
    end
    if (c != hafcr_pkg::CH_CLOSE) begin
      if (frame_open) begin
        if (c >= "0" && c <= "9") begin
          nib = 4'(c - 8'h30);
        end else if (c >= "A" && c <= "F") begin
          nib = 4'(c - 8'h41 + 8'h0A);
        end
        if (bytes_done >= hafcr_pkg::FRAME_BYTES) begin
          ovf_flag = 1'b1;
        end else if (!low_half) begin
          if (bytes_done < hafcr_pkg::HDR_DEPTH) hdr_bytes[bytes_done] |= {nib, 4'h0};
        end else begin
          if (bytes_done < hafcr_pkg::HDR_DEPTH) hdr_bytes[bytes_done] |= {4'h0, nib};
          bytes_done++;
        end
        low_half = !low_half;
      end
      return 1'b0;
    end
    frame_open = 1'b0;
    case (hdr_bytes[0])
      hafcr_pkg::HDR_CMD_DIR: begin
        r.kind = hafcr_pkg::CMD_DIR;
        r.line_follow_mode = hdr_bytes[1];
        if (hdr_bytes[1] == 8'h00) begin
          r.direction_code = hdr_bytes[2];
          r.direction_valid = 1'b1;
        end else begin
          r.recompute_direction = 1'b1;
        end
      end
      hafcr_pkg::HDR_CMD_LED: begin
        r.kind = hafcr_pkg::CMD_LED;
        r.led_pattern = hdr_bytes[1];
      end
      hafcr_pkg::HDR_CMD_SENSOR: r.kind = hafcr_pkg::CMD_SENSOR;
      default: r.kind = hafcr_pkg::CMD_NONE;
    endcase
    r.payload_bytes = 6'((bytes_done > 63) ? 63 : bytes_done);
    r.overflow = ovf_flag;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] c, input bit fixed = 1'b0,
                           input hafcr_pkg::result_t want = '0);
    hafcr_pkg::result_t r;
    if (frame_open || c == hafcr_pkg::CH_OPEN || c == hafcr_pkg::CH_CLOSE) items_done++;
    if (decode_char(c, r)) pending_results.push_back(fixed ? want : r);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_nibble(input logic [3:0] n);
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) begin
      if (n >= 4'hA) begin
        c = 8'h61 + 8'(n) - 8'h0A;
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == hafcr_pkg::CH_OPEN || c == hafcr_pkg::CH_CLOSE);
      end
    end else begin
      c = (n < 4'hA) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'h0A;
    end
    send_char(c);
  endtask

  task automatic send_frame(input bit force_long);
    int style;
    int nbytes;
    logic [7:0] b;
    style = force_long ? 0 : $urandom_range(0, 99);
    if (style < 75) begin
      send_char(hafcr_pkg::CH_OPEN);
      if (force_long || $urandom_range(0, 9) == 0) nbytes = $urandom_range(30, 40);
      else nbytes = $urandom_range(0, 4);
      for (int k = 0; k < nbytes; k++) begin
        b = 8'($urandom_range(0, 255));
        if (k == 0) begin
          case ($urandom_range(0, 4))
            0: b = hafcr_pkg::HDR_CMD_DIR;
            1: b = hafcr_pkg::HDR_CMD_LED;
            2: b = hafcr_pkg::HDR_CMD_SENSOR;
            3: b = hafcr_pkg::HDR_CMD_DIR;
            default: ;
          endcase
        end else if (k == 1 && $urandom_range(0, 1) == 0) begin
          b = 8'h00;
        end
        send_nibble(b[7:4]);
        send_nibble(b[3:0]);
      end
      if ($urandom_range(0, 4) == 0) send_nibble(4'($urandom_range(0, 15)));
      if ($urandom_range(0, 9) != 0) send_char(hafcr_pkg::CH_CLOSE);
    end else if (style < 88) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
    end else begin
      send_char(hafcr_pkg::CH_OPEN);
      repeat ($urandom_range(0, 3)) send_nibble(4'($urandom_range(0, 15)));
      send_char($urandom_range(0, 1) ? hafcr_pkg::CH_OPEN : hafcr_pkg::CH_CLOSE);
      repeat ($urandom_range(0, 2)) send_nibble(4'($urandom_range(0, 15)));
      send_char(hafcr_pkg::CH_CLOSE);
    end
  endtask

  function automatic void compare_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want_v, got_v);
    end
  endfunction

  // receiver side, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    hafcr_pkg::result_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
      end else begin
        w = pending_results.pop_front();
        compare_field("command_kind", 8'(w.kind), 8'(command_kind));
        compare_field("line_follow_mode", w.line_follow_mode, line_follow_mode);
        compare_field("direction_code", w.direction_code, direction_code);
        compare_field("direction_valid", 8'(w.direction_valid), 8'(direction_valid));
        compare_field("recompute_direction", 8'(w.recompute_direction),
                      8'(recompute_direction));
        compare_field("led_pattern", w.led_pattern, led_pattern);
        compare_field("payload_bytes", 8'(w.payload_bytes), 8'(payload_bytes));
        compare_field("overflow", 8'(w.overflow), 8'(overflow));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("hex_ascii_frame_command_receiver_core verification failed");
    $finish;
  end

  initial begin
    int phase_end;
    int drain;
    frame_open = 1'b0;
    bytes_done = 0;
    low_half = 1'b0;
    ovf_flag = 1'b0;
    foreach (hdr_bytes[j]) hdr_bytes[j] = 8'h00;
    dir_tab = '{
      '{hafcr_pkg::CH_CLOSE, 1'b1, frame_result(hafcr_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0,
                                                1'b0, 8'h00, 6'd0, 1'b0)},
      '{8'h41, 1'b0, '0},
      '{hafcr_pkg::CH_OPEN, 1'b0, '0}, '{8'h30, 1'b0, '0}, '{8'h31, 1'b0, '0},
      '{8'h30, 1'b0, '0}, '{8'h30, 1'b0, '0}, '{8'h31, 1'b0, '0}, '{8'h46, 1'b0, '0},
      '{hafcr_pkg::CH_CLOSE, 1'b1, frame_result(hafcr_pkg::CMD_DIR, 8'h00, 8'h1F, 1'b1,
                                                1'b0, 8'h00, 6'd3, 1'b0)},
      '{hafcr_pkg::CH_OPEN, 1'b0, '0}, '{8'h30, 1'b0, '0}, '{8'h32, 1'b0, '0},
      '{8'h46, 1'b0, '0}, '{8'h46, 1'b0, '0},
      '{hafcr_pkg::CH_CLOSE, 1'b1, frame_result(hafcr_pkg::CMD_LED, 8'h00, 8'h00, 1'b0,
                                                1'b0, 8'hFF, 6'd2, 1'b0)},
      '{hafcr_pkg::CH_OPEN, 1'b0, '0}, '{8'h30, 1'b0, '0}, '{8'h34, 1'b0, '0},
      '{hafcr_pkg::CH_CLOSE, 1'b1, frame_result(hafcr_pkg::CMD_SENSOR, 8'h00, 8'h00, 1'b0,
                                                1'b0, 8'h00, 6'd1, 1'b0)},
      // stale header decoded again
      '{hafcr_pkg::CH_CLOSE, 1'b1, frame_result(hafcr_pkg::CMD_SENSOR, 8'h00, 8'h00, 1'b0,
                                                1'b0, 8'h00, 6'd1, 1'b0)},
      // reopened frame, extreme byte values as non-hex characters
      '{hafcr_pkg::CH_OPEN, 1'b0, '0}, '{8'hFF, 1'b0, '0},
      '{hafcr_pkg::CH_OPEN, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{hafcr_pkg::CH_CLOSE, 1'b1, frame_result(hafcr_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0,
                                                1'b0, 8'h00, 6'd0, 1'b0)}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_char(dir_tab[i].ch, dir_tab[i].fixed, dir_tab[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct <= 0;  stall_pct <= 0;  end
        1: begin gap_pct <= 47; stall_pct <= 0;  end
        2: begin gap_pct <= 0;  stall_pct <= 47; end
        default: begin gap_pct <= 6; stall_pct <= 6; end
      endcase
      if (ph == 0) begin
        send_frame(1'b1);
        // back-to-back short commands against a stalled output
        hold_requests <= hold_requests + 1;
        repeat (30) begin
          send_char(hafcr_pkg::CH_OPEN);
          send_nibble(4'($urandom_range(0, 4)));
          send_nibble(4'($urandom_range(0, 4)));
          send_char(hafcr_pkg::CH_CLOSE);
        end
      end
      phase_end = 26 + (ph + 1) * RANDOM_ITEMS / 4;
      while (items_done < phase_end) send_frame(1'b0);
    end
    in_valid <= 1'b0;

    for (drain = 0; drain < 20000 && pending_results.size() != 0; drain++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected result words never arrived", pending_results.size());
    end
    if (mismatches == 0) begin
      $display("hex_ascii_frame_command_receiver_core verification clean");
    end else begin
      $display("hex_ascii_frame_command_receiver_core verification failed");
    end
    $finish;
  end

endmodule
